@@ rtl/core/secded_pkg.sv @@
// secded_pkg: types, masks, codes and bit-placement helpers for the (16,11) SECDED codec.
// Standalone; imported by every module of the codec.
package secded_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned DATA_W = 11;
	localparam int unsigned SYN_W  = 4;

	localparam logic [WORD_W-1:0] MASK_P0 = 16'h5555;
	localparam logic [WORD_W-1:0] MASK_P1 = 16'h6666;
	localparam logic [WORD_W-1:0] MASK_P2 = 16'h7878;
	localparam logic [WORD_W-1:0] MASK_P3 = 16'h7F80;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAN     = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_DOUBLE    = 2'd2
	} status_t;

	typedef struct packed {
		logic              operation;
		logic [WORD_W-1:0] data_word;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic [1:0]        status;
	} rsp_t;

	// Stage two contents passed from the syndrome unit to the correction unit
	typedef struct packed {
		logic              valid;
		logic              operation;
		logic [WORD_W-1:0] word;
		logic [SYN_W-1:0]  syn;
		logic              odd;
	} syn_stage_t;

	// Spread payload bits to code word bits 2, 4..6 and 8..14; check bits left clear
	function automatic logic [WORD_W-1:0] place_data(input logic [DATA_W-1:0] d);
		logic [WORD_W-1:0] w;
		w        = '0;
		w[2]     = d[0];
		w[6:4]   = d[3:1];
		w[14:8]  = d[10:4];
		return w;
	endfunction

	function automatic logic [DATA_W-1:0] extract_data(input logic [WORD_W-1:0] w);
		return {w[14:8], w[6:4], w[2]};
	endfunction

endpackage

@@ rtl/core/secded_syn.sv @@
// secded_syn: second pipeline stage, computes the four check parities and overall parity.
// Depends on secded_pkg.
module secded_syn import secded_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic              op_s1,
	input  logic [WORD_W-1:0] word_s1,
	output syn_stage_t        stage_s2
);

	logic [SYN_W-1:0]  syn;
	logic              valid_s2;
	logic              op_s2;
	logic [WORD_W-1:0] word_s2;
	logic [SYN_W-1:0]  syn_s2;
	logic              odd_s2;

	// For encode the check bits are still clear, so these are the check bits themselves
	assign syn = {^(word_s1 & MASK_P3), ^(word_s1 & MASK_P2),
	              ^(word_s1 & MASK_P1), ^(word_s1 & MASK_P0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		word_s2 <= word_s1;
		syn_s2  <= syn;
		odd_s2  <= ^word_s1;
	end

	assign stage_s2 = {valid_s2, op_s2, word_s2, syn_s2, odd_s2};

endmodule

@@ rtl/core/secded_fix.sv @@
// secded_fix: third pipeline stage, inserts check bits or corrects and unpacks the payload.
// Depends on secded_pkg; fed by secded_syn.
module secded_fix import secded_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  syn_stage_t stage_s2,
	output logic       valid_s3,
	output rsp_t       rsp_s3
);

	logic [WORD_W-1:0] enc_word;
	logic [WORD_W-1:0] flip;
	logic [WORD_W-1:0] fixed_word;
	logic              syn_nz;
	rsp_t              rsp;

	assign syn_nz = |stage_s2.syn;

	always_comb begin
		enc_word     = stage_s2.word;
		enc_word[0]  = stage_s2.syn[0];
		enc_word[1]  = stage_s2.syn[1];
		enc_word[3]  = stage_s2.syn[2];
		enc_word[7]  = stage_s2.syn[3];
		// overall parity covers the data bits and the newly set check bits
		enc_word[15] = stage_s2.odd ^ (^stage_s2.syn);
	end

	assign flip       = syn_nz ? (WORD_W'(1) << (stage_s2.syn - SYN_W'(1))) : '0;
	assign fixed_word = stage_s2.word ^ flip;

	always_comb begin
		rsp = '0;
		if (stage_s2.operation == OP_ENCODE) begin
			rsp.result_word = enc_word;
			rsp.status      = ST_CLEAN;
		end else if (syn_nz && !stage_s2.odd) begin
			rsp.result_word = '0;
			rsp.status      = ST_DOUBLE;
		end else begin
			rsp.result_word = WORD_W'(extract_data(fixed_word));
			rsp.status      = stage_s2.odd ? ST_CORRECTED : ST_CLEAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= stage_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s3 <= rsp;
	end

	// Encoded words must leave with even overall parity and a clean status
	a_enc_even: assert property (@(posedge clk) disable iff (!arst_n)
		stage_s2.valid && stage_s2.operation == OP_ENCODE
		|=> (^rsp_s3.result_word) == 1'b0 && rsp_s3.status == ST_CLEAN)
		else $error("encoded word has odd parity");

	a_double_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && rsp_s3.status == ST_DOUBLE |-> rsp_s3.result_word == '0)
		else $error("double error result not cleared");

	a_dec_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		stage_s2.valid && stage_s2.operation == OP_DECODE
		|=> rsp_s3.result_word[WORD_W-1:DATA_W] == '0)
		else $error("decoded payload not zero-extended");

endmodule

@@ rtl/core/secded_16_11_codec_top.sv @@
// secded_16_11_codec_top: extended Hamming (16,11) SECDED encoder/decoder, three-stage pipeline.
// Depends on secded_pkg, secded_syn and secded_fix.
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+---------------------------------------------
//  request   | start, busy, request       | taken on an edge with start high, busy low
//  result    | done, result               | done high for one cycle; must be taken then
//
// One request per cycle; each result passes the input register, syndrome stage and correction
// stage in that order after its request is taken. busy is always low: the pipeline
// never holds, since the receiver cannot stall. Reset clears the stage valid bits only.
module secded_16_11_codec_top import secded_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	logic              valid_s1;
	logic              op_s1;
	logic [WORD_W-1:0] word_s1;
	syn_stage_t        stage_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Encode spreads the payload now so the next stage sees one word shape for both operations
	always_ff @(posedge clk) begin
		op_s1 <= request.operation;
		if (request.operation == OP_ENCODE) begin
			word_s1 <= place_data(request.data_word[DATA_W-1:0]);
		end else begin
			word_s1 <= request.data_word;
		end
	end

	secded_syn u_syn (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.word_s1  (word_s1),
		.stage_s2 (stage_s2)
	);

	secded_fix u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s2 (stage_s2),
		.valid_s3 (done),
		.rsp_s3   (result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing three cycles after request");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1, 2))
		else $error("result strobe without a request");

endmodule
